@@ design/plu_pkg.sv @@
// ----------------------------------------------------------------------------
// plu_pkg
// Types, stage map and constants shared by the point light shade unit.
// ----------------------------------------------------------------------------
package plu_pkg;

   localparam int FIFO_DEPTH_DEF = 4;

   localparam int SQRT_BITS = 18;
   localparam int DIV_BITS  = 15;
   localparam int POW_STEPS = 16;

   localparam logic [14:0] ONE_Q14 = 15'd16384;

   localparam int ST_SQ      = 0;
   localparam int ST_SUM     = 1;
   localparam int ST_SQRT0   = 2;
   localparam int ST_DIVI    = ST_SQRT0 + SQRT_BITS;
   localparam int ST_DIV0    = ST_DIVI + 1;
   localparam int ST_LV      = ST_DIV0 + DIV_BITS;
   localparam int ST_LDN     = ST_LV + 1;
   localparam int ST_R       = ST_LDN + 1;
   localparam int ST_RE      = ST_R + 1;
   localparam int ST_RDE     = ST_RE + 1;
   localparam int ST_POW0    = ST_RDE + 1;
   localparam int ST_MUL     = ST_POW0 + POW_STEPS;
   localparam int ST_PROD    = ST_MUL + 1;
   localparam int ST_OUT     = ST_PROD + 1;
   localparam int NUM_STAGES = ST_OUT + 1;

   typedef struct packed {
      logic [2:0][16:0] d;
      logic [2:0][15:0] e;
      logic [2:0][15:0] n;
      logic [2:0][15:0] li;
      logic [2:0][31:0] eff;
      logic [12:0]      ka;
      logic [12:0]      kd;
      logic [12:0]      ks;
      logic [7:0]       shin;
      logic             shadow;
   } fe_type;

   typedef struct packed {
      fe_type           fe;
      logic [2:0][33:0] sq;
      logic [17:0]      root;
      logic [36:0]      rem;
      logic [2:0][30:0] drem;
      logic [2:0][14:0] q;
      logic [2:0][15:0] lv;
      logic [2:0][31:0] ln;
      logic             diff_on;
      logic [14:0]      ldn14;
      logic [2:0][17:0] r;
      logic [2:0][33:0] re;
      logic             spec_on;
      logic [14:0]      base;
      logic [14:0]      f;
      logic [2:0][44:0] ta;
      logic [2:0][44:0] tb;
      logic [2:0][28:0] tc;
      logic [2:0][58:0] pa;
      logic [2:0][59:0] pb;
      logic [2:0][55:0] pc;
      logic [2:0][15:0] colour;
   } bk_type;

endpackage

@@ design/phong_point_light_shade_unit.sv @@
// ----------------------------------------------------------------------------
// phong_point_light_shade_unit
// Phong shading of one surface point under one point light, fixed point.
// ----------------------------------------------------------------------------
// Takes one word per cycle while req_ready is high and returns one RGB word
// per input, in order. Path: one input register, the queue, and a 60-stage
// back pipeline (18 square-root stages, 15 normalize-divide stages, 16
// shininess power stages and the dot-product and color stages).
// A stalled result holds the back pipeline; the front keeps filling the
// queue until it is full.
module phong_point_light_shade_unit import plu_pkg::*; #(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [47:0] req_point_xyz,
   input  logic [47:0] req_eye_xyz,
   input  logic [47:0] req_normal_xyz,
   input  logic [47:0] req_light_position_xyz,
   input  logic [47:0] req_light_intensity_rgb,
   input  logic [47:0] req_surface_colour_rgb,
   input  logic [12:0] req_ambient_factor,
   input  logic [12:0] req_diffuse_factor,
   input  logic [12:0] req_specular_factor,
   input  logic [7:0]  req_shininess_power,
   input  logic        req_in_shadow,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_colour_r,
   output logic [15:0] rsp_colour_g,
   output logic [15:0] rsp_colour_b
);

   logic             fr_valid;
   logic             fr_ready;
   fe_type           fr_data;
   logic             q_valid;
   logic             q_ready;
   fe_type           q_data;
   logic [2:0][15:0] colour;

   plu_front u_front (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_point_xyz           (req_point_xyz),
      .req_eye_xyz             (req_eye_xyz),
      .req_normal_xyz          (req_normal_xyz),
      .req_light_position_xyz  (req_light_position_xyz),
      .req_light_intensity_rgb (req_light_intensity_rgb),
      .req_surface_colour_rgb  (req_surface_colour_rgb),
      .req_ambient_factor      (req_ambient_factor),
      .req_diffuse_factor      (req_diffuse_factor),
      .req_specular_factor     (req_specular_factor),
      .req_shininess_power     (req_shininess_power),
      .req_in_shadow           (req_in_shadow),
      .out_valid               (fr_valid),
      .out_ready               (fr_ready),
      .out_data                (fr_data)
   );

   plu_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (fr_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   plu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_valid),
      .in_ready   (q_ready),
      .in_data    (q_data),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_colour (colour)
   );

   assign rsp_colour_r = colour[0];
   assign rsp_colour_g = colour[1];
   assign rsp_colour_b = colour[2];

endmodule

@@ design/plu_front.sv @@
// ----------------------------------------------------------------------------
// plu_front
// Input stage: takes a word, forms light offsets and effective colour.
// ----------------------------------------------------------------------------
module plu_front import plu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [47:0] req_point_xyz,
   input  logic [47:0] req_eye_xyz,
   input  logic [47:0] req_normal_xyz,
   input  logic [47:0] req_light_position_xyz,
   input  logic [47:0] req_light_intensity_rgb,
   input  logic [47:0] req_surface_colour_rgb,
   input  logic [12:0] req_ambient_factor,
   input  logic [12:0] req_diffuse_factor,
   input  logic [12:0] req_specular_factor,
   input  logic [7:0]  req_shininess_power,
   input  logic        req_in_shadow,
   output logic        out_valid,
   input  logic        out_ready,
   output fe_type      out_data
);

   logic   vld_ff;
   logic   vld_in;
   fe_type data_ff;
   fe_type data_in;
   logic   take;

   assign req_ready = !vld_ff || out_ready;
   assign take      = req_valid && req_ready;
   assign vld_in    = take || (vld_ff && !out_ready);

   always_comb begin
      logic [15:0] lp;
      logic [15:0] pp;
      logic [15:0] cc;
      data_in = '0;
      for (int i = 0; i < 3; i++) begin
         lp = req_light_position_xyz[16*i +: 16];
         pp = req_point_xyz[16*i +: 16];
         cc = req_surface_colour_rgb[16*i +: 16];
         data_in.d[i]   = {lp[15], lp} - {pp[15], pp};
         data_in.e[i]   = req_eye_xyz[16*i +: 16];
         data_in.n[i]   = req_normal_xyz[16*i +: 16];
         data_in.li[i]  = req_light_intensity_rgb[16*i +: 16];
         data_in.eff[i] = {16'b0, cc} * {16'b0, req_light_intensity_rgb[16*i +: 16]};
      end
      data_in.ka     = req_ambient_factor;
      data_in.kd     = req_diffuse_factor;
      data_in.ks     = req_specular_factor;
      data_in.shin   = req_shininess_power;
      data_in.shadow = req_in_shadow;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule

@@ design/plu_fifo.sv @@
// ----------------------------------------------------------------------------
// plu_fifo
// Short queue between the front and the back pipeline.
// ----------------------------------------------------------------------------
module plu_fifo import plu_pkg::*; #(
   parameter int DEPTH = FIFO_DEPTH_DEF
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   in_valid,
   output logic   in_ready,
   input  fe_type in_data,
   output logic   out_valid,
   input  logic   out_ready,
   output fe_type out_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   fe_type          mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff;
   logic [AW-1:0]   wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff;
   logic [AW-1:0]   rd_ptr_in;
   logic [CW-1:0]   cnt_ff;
   logic [CW-1:0]   cnt_in;
   logic            push;
   logic            pop;

   assign in_ready  = cnt_ff != CW'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

@@ design/plu_back.sv @@
// ----------------------------------------------------------------------------
// plu_back
// Shading pipeline: length, normalize, dot products, power, color sum.
// ----------------------------------------------------------------------------
module plu_back import plu_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  fe_type           in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [2:0][15:0] out_colour
);

   bk_type                  cur    [NUM_STAGES];
   bk_type                  stg_in [NUM_STAGES];
   bk_type                  stg_ff [NUM_STAGES];
   logic [NUM_STAGES-1:0]   vld_ff;
   logic [NUM_STAGES-1:0]   vld_in;
   logic                    en;

   assign en       = !vld_ff[NUM_STAGES-1] || out_ready;
   assign in_ready = en;
   assign vld_in   = {vld_ff[NUM_STAGES-2:0], in_valid};

   always_comb begin
      cur[0]    = '0;
      cur[0].fe = in_data;
   end

   for (genvar g = 1; g < NUM_STAGES; g++) begin : g_cur
      assign cur[g] = stg_ff[g-1];
   end

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
      if (g == ST_SQ) begin : g_sq
         always_comb begin
            logic [33:0] dx;
            stg_in[g] = cur[g];
            for (int i = 0; i < 3; i++) begin
               dx = {{17{cur[g].fe.d[i][16]}}, cur[g].fe.d[i]};
               stg_in[g].sq[i] = $signed(dx) * $signed(dx);
            end
         end
      end else if (g == ST_SUM) begin : g_sum
         always_comb begin
            stg_in[g]      = cur[g];
            stg_in[g].rem  = {3'b0, cur[g].sq[0]} + {3'b0, cur[g].sq[1]}
                           + {3'b0, cur[g].sq[2]};
            stg_in[g].root = '0;
         end
      end else if (g >= ST_SQRT0 && g < ST_DIVI) begin : g_sqrt
         localparam int K = SQRT_BITS - 1 - (g - ST_SQRT0);
         always_comb begin
            logic [36:0] t;
            stg_in[g] = cur[g];
            t = ({19'b0, cur[g].root} << (K + 1)) | ({36'b0, 1'b1} << (2 * K));
            if (cur[g].rem >= t) begin
               stg_in[g].rem  = cur[g].rem - t;
               stg_in[g].root = cur[g].root | (18'd1 << K);
            end
         end
      end else if (g == ST_DIVI) begin : g_divi
         always_comb begin
            logic [16:0] mag;
            stg_in[g] = cur[g];
            for (int i = 0; i < 3; i++) begin
               mag = cur[g].fe.d[i][16] ? -cur[g].fe.d[i] : cur[g].fe.d[i];
               stg_in[g].drem[i] = {1'b0, mag[15:0], 14'b0};
               stg_in[g].q[i]    = '0;
            end
         end
      end else if (g >= ST_DIV0 && g < ST_LV) begin : g_div
         localparam int K = DIV_BITS - 1 - (g - ST_DIV0);
         always_comb begin
            logic [32:0] tl;
            stg_in[g] = cur[g];
            tl = {15'b0, cur[g].root} << K;
            for (int i = 0; i < 3; i++) begin
               if ({2'b0, cur[g].drem[i]} >= tl) begin
                  stg_in[g].drem[i] = cur[g].drem[i] - tl[30:0];
                  stg_in[g].q[i]    = cur[g].q[i] | (15'd1 << K);
               end
            end
         end
      end else if (g == ST_LV) begin : g_lv
         always_comb begin
            logic [15:0] lv;
            stg_in[g] = cur[g];
            for (int i = 0; i < 3; i++) begin
               if (cur[g].root == '0) begin
                  lv = '0;
               end else if (cur[g].fe.d[i][16]) begin
                  lv = -{1'b0, cur[g].q[i]};
               end else begin
                  lv = {1'b0, cur[g].q[i]};
               end
               stg_in[g].lv[i] = lv;
               stg_in[g].ln[i] = $signed({{16{lv[15]}}, lv})
                               * $signed({{16{cur[g].fe.n[i][15]}}, cur[g].fe.n[i]});
            end
         end
      end else if (g == ST_LDN) begin : g_ldn
         always_comb begin
            logic [33:0] s;
            stg_in[g] = cur[g];
            s = {{2{cur[g].ln[0][31]}}, cur[g].ln[0]}
              + {{2{cur[g].ln[1][31]}}, cur[g].ln[1]}
              + {{2{cur[g].ln[2][31]}}, cur[g].ln[2]};
            stg_in[g].diff_on = !cur[g].fe.shadow && !s[33];
            stg_in[g].ldn14   = (s[33:14] > 20'd16384) ? ONE_Q14 : s[28:14];
         end
      end else if (g == ST_R) begin : g_r
         always_comb begin
            logic [32:0] p;
            logic [18:0] r;
            stg_in[g] = cur[g];
            for (int i = 0; i < 3; i++) begin
               p = $signed({17'b0, cur[g].ldn14, 1'b0})
                 * $signed({{17{cur[g].fe.n[i][15]}}, cur[g].fe.n[i]});
               r = p[32:14] - {{3{cur[g].lv[i][15]}}, cur[g].lv[i]};
               stg_in[g].r[i] = r[17:0];
            end
         end
      end else if (g == ST_RE) begin : g_re
         always_comb begin
            stg_in[g] = cur[g];
            for (int i = 0; i < 3; i++) begin
               stg_in[g].re[i] = $signed({{16{cur[g].r[i][17]}}, cur[g].r[i]})
                               * $signed({{18{cur[g].fe.e[i][15]}}, cur[g].fe.e[i]});
            end
         end
      end else if (g == ST_RDE) begin : g_rde
         always_comb begin
            logic [35:0] s;
            stg_in[g] = cur[g];
            s = {{2{cur[g].re[0][33]}}, cur[g].re[0]}
              + {{2{cur[g].re[1][33]}}, cur[g].re[1]}
              + {{2{cur[g].re[2][33]}}, cur[g].re[2]};
            stg_in[g].spec_on = cur[g].diff_on && !s[35] && (s != '0);
            stg_in[g].base    = (s[35:14] > 22'd16384) ? ONE_Q14 : s[28:14];
            stg_in[g].f       = ONE_Q14;
         end
      end else if (g >= ST_POW0 && g < ST_MUL) begin : g_pow
         localparam int J = g - ST_POW0;
         localparam int B = 7 - J / 2;
         always_comb begin
            logic [29:0] p;
            stg_in[g] = cur[g];
            if (J % 2 == 0) begin
               p = {15'b0, cur[g].f} * {15'b0, cur[g].f};
               stg_in[g].f = p[28:14];
            end else begin
               p = {15'b0, cur[g].f} * {15'b0, cur[g].base};
               if (cur[g].fe.shin[B]) begin
                  stg_in[g].f = p[28:14];
               end
            end
         end
      end else if (g == ST_MUL) begin : g_mul
         always_comb begin
            stg_in[g] = cur[g];
            for (int i = 0; i < 3; i++) begin
               stg_in[g].ta[i] = {13'b0, cur[g].fe.eff[i]} * {32'b0, cur[g].fe.ka};
               stg_in[g].tb[i] = {13'b0, cur[g].fe.eff[i]} * {32'b0, cur[g].fe.kd};
               stg_in[g].tc[i] = {13'b0, cur[g].fe.li[i]} * {16'b0, cur[g].fe.ks};
            end
         end
      end else if (g == ST_PROD) begin : g_prod
         always_comb begin
            logic [43:0] sp;
            stg_in[g] = cur[g];
            for (int i = 0; i < 3; i++) begin
               sp = {15'b0, cur[g].tc[i]} * {29'b0, cur[g].f};
               stg_in[g].pa[i] = {cur[g].ta[i], 14'b0};
               stg_in[g].pb[i] = cur[g].diff_on
                               ? {15'b0, cur[g].tb[i]} * {45'b0, cur[g].ldn14} : '0;
               stg_in[g].pc[i] = cur[g].spec_on ? {sp, 12'b0} : '0;
            end
         end
      end else begin : g_out
         always_comb begin
            logic [61:0] s;
            stg_in[g] = cur[g];
            for (int i = 0; i < 3; i++) begin
               s = {3'b0, cur[g].pa[i]} + {2'b0, cur[g].pb[i]} + {6'b0, cur[g].pc[i]};
               stg_in[g].colour[i] = (s[61:54] != '0) ? 16'hFFFF : s[53:38];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stg_ff <= stg_in;
      end
   end

   assign out_valid  = vld_ff[NUM_STAGES-1];
   assign out_colour = stg_ff[NUM_STAGES-1].colour;

endmodule

@@ design/plu_checker.sv @@
// ----------------------------------------------------------------------------
// plu_checker
// Port-level checks for the shade unit, bound to the top level.
// ----------------------------------------------------------------------------
module plu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_colour_r,
   input logic [15:0] rsp_colour_g,
   input logic [15:0] rsp_colour_b
);

   logic [7:0] pend_ff;
   logic [7:0] pend_in;
   logic       acc_in;
   logic       acc_out;

   assign acc_in  = req_valid && req_ready;
   assign acc_out = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (acc_in && !acc_out) begin
         pend_in = pend_ff + 1'b1;
      end else if (acc_out && !acc_in) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 8'd0)
      else $error("result word without a pending request");

   a_stall_has_work: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> pend_ff != 8'd0)
      else $error("input stalled while empty");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_colour_r)
         && $stable(rsp_colour_g) && $stable(rsp_colour_b))
      else $error("stalled result word changed");

endmodule

bind phong_point_light_shade_unit plu_checker u_plu_checker (.*);

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the point light shade unit.
// ----------------------------------------------------------------------------
// Random and directed shading words go in with bursty valid and random
// result stalls; a scoreboard predicts each Phong color in fixed point and
// checks the results in order.
`timescale 1ns / 1ps

class shade_scoreboard;
   logic [2:0][15:0] colour_q[$];
   int               errors;
   int               checked;

   function automatic logic signed [63:0] lane_s(logic [47:0] v, int k);
      logic [15:0] u;
      u = v[16*k +: 16];
      return 64'(signed'(u));
   endfunction

   function automatic logic signed [63:0] floor14(logic signed [63:0] v);
      return v >>> 14;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] s);
      logic [63:0] r, bt;
      r = 0;
      bt = 64'd1 << 62;
      while (bt > s) bt = bt >> 2;
      while (bt != 0) begin
         if (s >= r + bt) begin
            s = s - (r + bt);
            r = (r >> 1) + bt;
         end else begin
            r = r >> 1;
         end
         bt = bt >> 2;
      end
      return r;
   endfunction

   function void note_word(logic [47:0] pt, logic [47:0] ey, logic [47:0] nm,
                           logic [47:0] lp, logic [47:0] li, logic [47:0] sc,
                           logic [12:0] ka, logic [12:0] kd, logic [12:0] ks,
                           logic [7:0] shin, logic shadow);
      logic signed [63:0] d[3], lv[3], n[3], e[3], rr[3];
      logic signed [63:0] ldn, rde, l14, r14, q;
      logic [63:0] s2, len, ldn14, f, mag, c, lt, eff, sum, res;
      logic        diff_on, spec_on;
      logic [2:0][15:0] outc;
      s2 = 0; ldn = 0; rde = 0; ldn14 = 0; f = 0;
      diff_on = 0; spec_on = 0;
      for (int k = 0; k < 3; k++) begin
         d[k] = lane_s(lp, k) - lane_s(pt, k);
         e[k] = lane_s(ey, k);
         n[k] = lane_s(nm, k);
         s2 = s2 + 64'(d[k] * d[k]);
      end
      len = int_sqrt(s2);
      for (int k = 0; k < 3; k++) begin
         if (len == 0) lv[k] = 0;
         else begin
            mag = d[k] < 0 ? 64'(-d[k]) : 64'(d[k]);
            q = signed'((mag * 16384) / len);
            lv[k] = d[k] < 0 ? -q : q;
         end
         ldn = ldn + lv[k] * n[k];
      end
      if (!shadow && ldn >= 0) begin
         diff_on = 1;
         l14 = floor14(ldn);
         if (l14 > 16384) l14 = 16384;
         ldn14 = l14;
         for (int k = 0; k < 3; k++) begin
            rr[k] = -lv[k] + floor14(2 * l14 * n[k]);
            rde = rde + rr[k] * e[k];
         end
         if (rde > 0) begin
            r14 = floor14(rde);
            if (r14 > 16384) r14 = 16384;
            f = 16384;
            for (int b = 7; b >= 0; b--) begin
               f = (f * f) >> 14;
               if (shin[b]) f = (f * 64'(r14)) >> 14;
            end
            spec_on = 1;
         end
      end
      for (int k = 0; k < 3; k++) begin
         c = 64'(sc[16*k +: 16]);
         lt = 64'(li[16*k +: 16]);
         eff = c * lt;
         sum = (eff * ka) << 14;
         if (diff_on) sum = sum + eff * kd * ldn14;
         if (spec_on) sum = sum + ((lt * ks * f) << 12);
         res = sum >> 38;
         outc[k] = res > 65535 ? 16'hFFFF : res[15:0];
      end
      colour_q.insert(colour_q.size(), outc);
   endfunction

   function void check_colour(logic [15:0] r, logic [15:0] g, logic [15:0] b);
      logic [2:0][15:0] want;
      logic [2:0][15:0] got;
      if (colour_q.size() == 0) begin
         $display("%0t: unexpected word r=%h g=%h b=%h", $time, r, g, b);
         errors++;
         return;
      end
      want = colour_q.pop_front();
      got[0] = r; got[1] = g; got[2] = b;
      checked++;
      for (int k = 0; k < 3; k++)
         if (want[k] !== got[k]) begin
            $display("%0t: channel %0d expected %h actual %h", $time, k, want[k], got[k]);
            errors++;
         end
   endfunction
endclass

module tb_top;
   import plu_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [47:0] req_point_xyz, req_eye_xyz, req_normal_xyz;
   logic [47:0] req_light_position_xyz, req_light_intensity_rgb, req_surface_colour_rgb;
   logic [12:0] req_ambient_factor, req_diffuse_factor, req_specular_factor;
   logic [7:0]  req_shininess_power;
   logic        req_in_shadow;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_colour_r, rsp_colour_g, rsp_colour_b;

   shade_scoreboard sb;
   int  words_sent;
   int  shadow_sent;
   bit  long_hold;
   bit  hold_done;
   int  idle_cycles;

   phong_point_light_shade_unit uut (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // pack three signed lanes
   function automatic logic [47:0] tri16(int x, int y, int z);
      return {16'(z), 16'(y), 16'(x)};
   endfunction

   function automatic logic [47:0] unit_vec();
      int a, b, c;
      a = $urandom_range(0, 16384);
      b = $urandom_range(0, 16384 - a);
      c = 16384 - a - b;
      if ($urandom_range(0, 1)) a = -a;
      if ($urandom_range(0, 1)) b = -b;
      if ($urandom_range(0, 1)) c = -c;
      return tri16(a, b, c);
   endfunction

   task automatic send_word(logic [47:0] pt, logic [47:0] ey, logic [47:0] nm,
                            logic [47:0] lp, logic [47:0] li, logic [47:0] sc,
                            logic [12:0] ka, logic [12:0] kd, logic [12:0] ks,
                            logic [7:0] shin, logic shadow);
      req_valid <= 1;
      req_point_xyz <= pt; req_eye_xyz <= ey; req_normal_xyz <= nm;
      req_light_position_xyz <= lp; req_light_intensity_rgb <= li;
      req_surface_colour_rgb <= sc; req_ambient_factor <= ka;
      req_diffuse_factor <= kd; req_specular_factor <= ks;
      req_shininess_power <= shin; req_in_shadow <= shadow;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(pt, ey, nm, lp, li, sc, ka, kd, ks, shin, shadow);
      words_sent++;
      if (shadow) shadow_sent++;
   endtask

   task automatic send_random(bit wild);
      logic [47:0] pt, ey, nm, lp;
      logic [12:0] ka, kd, ks;
      if (wild) begin
         pt = 48'({$urandom, $urandom}); ey = 48'({$urandom, $urandom});
         nm = 48'({$urandom, $urandom}); lp = 48'({$urandom, $urandom});
         ka = 13'($urandom); kd = 13'($urandom); ks = 13'($urandom);
      end else begin
         pt = tri16($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                    $urandom_range(0, 4095) - 2048);
         lp = tri16($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                    $urandom_range(0, 8191) - 4096);
         ey = unit_vec(); nm = unit_vec();
         ka = 13'($urandom_range(0, 4096)); kd = 13'($urandom_range(0, 4096));
         ks = 13'($urandom_range(0, 4096));
      end
      send_word(pt, ey, nm, lp, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                ka, kd, ks, 8'($urandom), $urandom_range(0, 5) == 0);
   endtask

   task automatic drain();
      while (sb.colour_q.size() != 0) @(posedge clock);
   endtask

   // receiver stall pattern
   initial begin
      int mode;
      rsp_ready = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 9);
         if (long_hold) begin
            rsp_ready <= 0;
            repeat (200) @(posedge clock);
            long_hold = 0;
         end else if (mode < 4) begin
            rsp_ready <= 1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end else begin
            rsp_ready <= mode < 8 ? 1'($urandom_range(0, 1)) : 1'b0;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_colour(rsp_colour_r, rsp_colour_g, rsp_colour_b);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", idle_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      logic [47:0] ones16, full;
      sb = new();
      idle_cycles = 0;
      reset = 1; req_valid = 0;
      req_point_xyz = 0; req_eye_xyz = 0; req_normal_xyz = 0;
      req_light_position_xyz = 0; req_light_intensity_rgb = 0;
      req_surface_colour_rgb = 0; req_ambient_factor = 0;
      req_diffuse_factor = 0; req_specular_factor = 0;
      req_shininess_power = 0; req_in_shadow = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      ones16 = tri16(16384, 0, 0);
      full = 48'hFFFF_FFFF_FFFF;
      // light straight above, eye along normal
      send_word(0, tri16(0, 0, 16384), tri16(0, 0, 16384), tri16(0, 0, 2560),
                full, full, 4096, 4096, 4096, 1, 0);
      send_word(0, tri16(0, 0, 16384), tri16(0, 0, 16384), tri16(0, 0, 2560),
                48'h1000_1000_1000, 48'h1000_1000_1000, 410, 2867, 4096, 200, 0);
      // in shadow
      send_word(0, tri16(0, 0, 16384), tri16(0, 0, 16384), tri16(0, 0, 2560),
                full, full, 4096, 4096, 4096, 255, 1);
      // light at the point
      send_word(tri16(256, -256, 512), ones16, ones16, tri16(256, -256, 512),
                full, full, 100, 4096, 4096, 10, 0);
      // light behind the surface
      send_word(0, ones16, ones16, tri16(-2560, 0, 0), full, full, 0, 4096, 4096, 3, 0);
      // shininess zero, factors above one, non-unit vectors
      send_word(0, tri16(32767, 32767, 32767), tri16(32767, 32767, 32767),
                tri16(32767, 32767, 32767), full, full, 8191, 8191, 8191, 0, 0);
      send_word(full, tri16(-32768, -32768, -32768), tri16(-32768, 0, 0),
                tri16(-32768, -32768, -32768), full, full, 8191, 8191, 8191, 255, 0);
      send_word(tri16(-32768, -32768, -32768), tri16(16384, 0, 0), ones16,
                tri16(32767, 32767, 32767), 0, 0, 0, 0, 0, 128, 0);
      // grazing light: ldn exactly zero
      send_word(0, tri16(0, 16384, 0), tri16(0, 0, 16384), tri16(2560, 0, 0),
                full, full, 0, 4096, 4096, 1, 0);
      // reflection away from eye
      send_word(0, tri16(0, 0, -16384), tri16(0, 0, 16384), tri16(1000, 0, 2000),
                full, full, 2000, 3000, 4096, 7, 0);
      for (int k = 0; k < 8; k++) send_random(k[0]);
      req_valid <= 0;

      // pause until everything is back
      drain();

      while (words_sent < 650) begin
         if (words_sent > 300 && !hold_done) begin
            long_hold = 1;
            hold_done = 1;
         end
         repeat ($urandom_range(1, 30)) send_random($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      req_valid <= 0;
      drain();
      repeat (100) @(posedge clock);
      $display("Run covered %0d words (%0d shadowed), %0d results checked.",
               words_sent, shadow_sent, sb.checked);
      if (sb.errors == 0 && sb.colour_q.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule

@@ files.f @@
design/plu_pkg.sv
design/plu_front.sv
design/plu_fifo.sv
design/plu_back.sv
design/phong_point_light_shade_unit.sv
design/plu_checker.sv
verif/tb_top.sv
